[rtl/per_channel_scale_requantize_core_assert.svh]
// assertion macros for the requantizer rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef PER_CHANNEL_SCALE_REQUANTIZE_CORE_ASSERT_SVH
`define PER_CHANNEL_SCALE_REQUANTIZE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define RQNT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RQNT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define RQNT_ASSERT(lbl, clk, rst_n, prop, msg)
`define RQNT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

[rtl/rqnt_pkg.sv]
// shared types and constants for the per-channel requantizer
// no dependencies
`default_nettype none

package rqnt_pkg;

	localparam int RQNT_CHANNELS = 64;
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 8;
	localparam int MC_W = $clog2(MID_DEPTH + 1);
	localparam int OC_W = $clog2(OUT_DEPTH + 1);
	localparam int PROD_W = 41;
	localparam int SUM_W = 42;

	typedef enum logic [2:0] {
		CFG_SIGNED_OUTPUT   = 3'd0,
		CFG_ASYMMETRIC_MODE = 3'd1,
		CFG_ZERO_POINT      = 3'd2,
		CFG_RELU_ENABLE     = 3'd3,
		CFG_RELU_CEILING    = 3'd4,
		CFG_NARROW_TO_16BIT = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic              signed_output;
		logic              asymmetric_mode;
		logic signed [8:0] zero_point;
		logic              relu_enable;
		logic [7:0]        relu_ceiling;
		logic              narrow_to_16bit;
	} cfg_t;

	typedef struct packed {
		logic [5:0]         channel;
		logic signed [8:0]  elem;
		logic signed [31:0] scale;
		logic signed [31:0] bias;
		logic signed [5:0]  shift;
	} mid_item_t;

	typedef struct packed {
		logic signed [8:0] value;
		logic [5:0]        channel;
	} out_item_t;

endpackage

`default_nettype wire

[rtl/rqnt_fifo.sv]
// small register queue used between front and back and at the output
// depends on per_channel_scale_requantize_core_assert.svh
`default_nettype none
`include "per_channel_scale_requantize_core_assert.svh"

module rqnt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr,
	input  wire logic [WIDTH-1:0]             wdata,
	input  wire logic                         rd,
	output logic      [WIDTH-1:0]             rdata,
	output logic                              empty,
	output logic      [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             full;
	logic             do_wr;
	logic             do_rd;

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));
	assign count = count_q;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`RQNT_NEVER(a_no_overflow, clk, arst_n, wr && full, "write into full queue")
	`RQNT_NEVER(a_count_range, clk, arst_n, count_q > CW'(DEPTH), "queue count out of range")
	`RQNT_ASSERT(a_count_up, clk, arst_n, (do_wr && !do_rd) |=> (count_q == $past(count_q) + 1'b1), "queue count did not grow")

endmodule

`default_nettype wire

[rtl/rqnt_front.sv]
// front part: accepts transactions, keeps the channel table, classifies
// depends on rqnt_pkg
`default_nettype none

module rqnt_front #(
	parameter int CHANNELS = rqnt_pkg::RQNT_CHANNELS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic                      func,
	input  wire logic [5:0]                channel,
	input  wire logic signed [8:0]         element_value,
	input  wire logic signed [31:0]        channel_scale,
	input  wire logic signed [31:0]        channel_bias,
	input  wire logic signed [5:0]         channel_right_shift,
	input  wire logic [rqnt_pkg::MC_W-1:0] mid_count,
	output logic                           mid_wr,
	output rqnt_pkg::mid_item_t            mid_item
);

	import rqnt_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ENT_W = 32 + 32 + 6;

	logic [ENT_W-1:0]  table_mem [CHANNELS];
	logic [ENT_W-1:0]  rd_s1;
	logic              v_s1;
	logic              inr_s1;
	logic [5:0]        ch_s1;
	logic signed [8:0] elem_s1;
	logic [IDX_W+5:0]  ch_ext;
	logic [IDX_W-1:0]  addr;
	logic              in_range;
	logic              accept;
	logic [MC_W:0]     occ;

	assign ch_ext   = {{IDX_W{1'b0}}, channel};
	assign addr     = ch_ext[IDX_W-1:0];
	assign in_range = (32'(channel) < 32'(CHANNELS));
	assign occ      = {1'b0, mid_count} + (MC_W + 1)'(v_s1);
	assign full     = (occ >= (MC_W + 1)'(MID_DEPTH));
	assign accept   = push && !full;

	always_ff @(posedge clk) begin
		if (accept && !func && in_range) begin
			table_mem[addr] <= {channel_scale, channel_bias, channel_right_shift};
		end
		if (accept && func) begin
			rd_s1 <= table_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && func) begin
			inr_s1  <= in_range;
			ch_s1   <= channel;
			elem_s1 <= element_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept && func;
		end
	end

	always_comb begin
		mid_item.channel = ch_s1;
		mid_item.elem    = elem_s1;
		if (inr_s1) begin
			mid_item.scale = rd_s1[69:38];
			mid_item.bias  = rd_s1[37:6];
			mid_item.shift = rd_s1[5:0];
		end else begin
			mid_item.scale = '0;
			mid_item.bias  = '0;
			mid_item.shift = '0;
		end
	end

	assign mid_wr = v_s1;

endmodule

`default_nettype wire

[rtl/rqnt_back.sv]
// back part: multiply, bias, clamp, shift, zero point, relu, saturate
// depends on rqnt_pkg and per_channel_scale_requantize_core_assert.svh
`default_nettype none
`include "per_channel_scale_requantize_core_assert.svh"

module rqnt_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire rqnt_pkg::cfg_t            cfg,
	input  wire logic                      mid_empty,
	input  wire rqnt_pkg::mid_item_t       mid_item,
	output logic                           mid_rd,
	input  wire logic [rqnt_pkg::OC_W-1:0] out_count,
	output logic                           out_wr,
	output rqnt_pkg::out_item_t            out_item
);

	import rqnt_pkg::*;

	localparam logic signed [SUM_W-1:0] S16_MIN = -SUM_W'(32768);
	localparam logic signed [SUM_W-1:0] S16_MAX = SUM_W'(32767);
	localparam logic signed [SUM_W-1:0] U16_MAX = SUM_W'(65535);
	localparam logic signed [SUM_W-1:0] L20_MIN = -SUM_W'(1048576);
	localparam logic signed [SUM_W-1:0] L20_MAX = SUM_W'(1048576);

	function automatic logic signed [15:0] clamp16(input logic signed [53:0] v);
		logic signed [15:0] r;
		if (v < -54'sd32768) begin
			r = -16'sd32768;
		end else if (v > 54'sd32767) begin
			r = 16'sd32767;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	logic                     v_s1, v_s2, v_s3;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [31:0]       bias_s1;
	logic signed [5:0]        shift_s1, shift_s2;
	logic [5:0]               ch_s1, ch_s2, ch_s3;
	logic signed [SUM_W-1:0]  sum_d, sum_c, sum_s2;
	logic signed [15:0]       c16_d, c16_s3;
	logic signed [SUM_W-1:0]  rs;
	logic signed [21:0]       c21;
	logic signed [53:0]       ls;
	logic [5:0]               lamt;
	logic signed [16:0]       v17;
	logic signed [8:0]        res;
	logic [OC_W+1:0]          occ;

	assign occ    = (OC_W + 2)'(out_count) + (OC_W + 2)'(v_s1) + (OC_W + 2)'(v_s2)
		+ (OC_W + 2)'(v_s3);
	assign mid_rd = !mid_empty && (occ < (OC_W + 2)'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= mid_rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: product
	always_ff @(posedge clk) begin
		if (mid_rd) begin
			prod_s1  <= mid_item.elem * mid_item.scale;
			bias_s1  <= mid_item.bias;
			shift_s1 <= mid_item.shift;
			ch_s1    <= mid_item.channel;
		end
	end

	// stage 2: bias and optional 16-bit clamp
	always_comb begin
		sum_d = SUM_W'(prod_s1) + SUM_W'(bias_s1);
		sum_c = sum_d;
		if (!cfg.asymmetric_mode && cfg.narrow_to_16bit) begin
			if (cfg.signed_output) begin
				if (sum_d < S16_MIN) begin
					sum_c = S16_MIN;
				end else if (sum_d > S16_MAX) begin
					sum_c = S16_MAX;
				end
			end else begin
				if (sum_d < 0) begin
					sum_c = '0;
				end else if (sum_d > U16_MAX) begin
					sum_c = U16_MAX;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			sum_s2   <= sum_c;
			shift_s2 <= shift_s1;
			ch_s2    <= ch_s1;
		end
	end

	// stage 3: floor right shift or clamped left shift
	always_comb begin
		rs   = sum_s2 >>> shift_s2[4:0];
		lamt = 6'(-shift_s2);
		if (sum_s2 < L20_MIN) begin
			c21 = L20_MIN[21:0];
		end else if (sum_s2 > L20_MAX) begin
			c21 = L20_MAX[21:0];
		end else begin
			c21 = sum_s2[21:0];
		end
		ls = 54'(c21) <<< lamt;
		if (shift_s2 > 0) begin
			c16_d = clamp16(54'(rs));
		end else if (shift_s2 < 0) begin
			c16_d = clamp16(ls);
		end else begin
			c16_d = clamp16(54'(sum_s2));
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			c16_s3 <= c16_d;
			ch_s3  <= ch_s2;
		end
	end

	// zero point, relu, saturation, relu ceiling
	always_comb begin
		v17 = 17'(c16_s3) + (cfg.asymmetric_mode ? 17'(cfg.zero_point) : 17'sd0);
		if (cfg.relu_enable && v17 < 0) begin
			v17 = '0;
		end
		if (cfg.signed_output) begin
			if (v17 < -17'sd128) begin
				res = -9'sd128;
			end else if (v17 > 17'sd127) begin
				res = 9'sd127;
			end else begin
				res = v17[8:0];
			end
		end else begin
			if (v17 < 0) begin
				res = '0;
			end else if (v17 > 17'sd255) begin
				res = 9'sd255;
			end else begin
				res = v17[8:0];
			end
		end
		if (cfg.relu_enable && cfg.relu_ceiling != '0
			&& res > $signed({1'b0, cfg.relu_ceiling})) begin
			res = $signed({1'b0, cfg.relu_ceiling});
		end
	end

	assign out_wr           = v_s3;
	assign out_item.value   = res;
	assign out_item.channel = ch_s3;

	`RQNT_ASSERT(a_s1_to_s2, clk, arst_n, v_s1 |=> v_s2, "stage 1 item did not advance")
	`RQNT_ASSERT(a_s2_to_s3, clk, arst_n, v_s2 |=> v_s3, "stage 2 item did not advance")
	`RQNT_NEVER(a_credit, clk, arst_n, occ > (OC_W + 2)'(OUT_DEPTH), "output credit exceeded")

endmodule

`default_nettype wire

[rtl/per_channel_scale_requantize_core.sv]
// top level of the per-channel requantizer: config registers and queues
// depends on rqnt_pkg, rqnt_fifo, rqnt_front, rqnt_back
//
// channel   handshake           payload
// input     push / full         func, channel, element_value, channel_scale,
//                               channel_bias, channel_right_shift
// result    empty / pop         result_value, result_channel
// config    cfg_write           cfg_index, cfg_data
//
// one transaction per cycle on each side; load transactions give no result
// a data transaction is on the result ports 5 cycles after its accepting edge:
// that edge reads the table, then front/back queue, multiply, bias, shift and
// output queue write take one cycle each
// reset clears control state only; table entries hold garbage until loaded
// full depends on front/back queue fill; the back issues only with room in
// the output queue, so either side can stall without losing transactions
`default_nettype none

module per_channel_scale_requantize_core #(
	parameter int CHANNELS = rqnt_pkg::RQNT_CHANNELS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic               func,
	input  wire logic [5:0]         channel,
	input  wire logic signed [8:0]  element_value,
	input  wire logic signed [31:0] channel_scale,
	input  wire logic signed [31:0] channel_bias,
	input  wire logic signed [5:0]  channel_right_shift,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [8:0]       result_value,
	output logic [5:0]              result_channel,
	input  wire logic               cfg_write,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [8:0]         cfg_data
);

	import rqnt_pkg::*;

	cfg_t            cfg_q;
	logic            mid_wr;
	mid_item_t       mid_witem;
	logic [$bits(mid_item_t)-1:0] mid_rdata;
	logic            mid_empty;
	logic            mid_rd;
	logic [MC_W-1:0] mid_count;
	logic            out_wr;
	out_item_t       out_witem;
	logic [$bits(out_item_t)-1:0] out_rdata;
	out_item_t       out_ritem;
	logic [OC_W-1:0] out_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.signed_output   <= 1'b1;
			cfg_q.asymmetric_mode <= 1'b0;
			cfg_q.zero_point      <= '0;
			cfg_q.relu_enable     <= 1'b0;
			cfg_q.relu_ceiling    <= '0;
			cfg_q.narrow_to_16bit <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SIGNED_OUTPUT:   cfg_q.signed_output   <= cfg_data[0];
				CFG_ASYMMETRIC_MODE: cfg_q.asymmetric_mode <= cfg_data[0];
				CFG_ZERO_POINT:      cfg_q.zero_point      <= cfg_data;
				CFG_RELU_ENABLE:     cfg_q.relu_enable     <= cfg_data[0];
				CFG_RELU_CEILING:    cfg_q.relu_ceiling    <= cfg_data[7:0];
				CFG_NARROW_TO_16BIT: cfg_q.narrow_to_16bit <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	rqnt_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.push                (push),
		.full                (full),
		.func                (func),
		.channel             (channel),
		.element_value       (element_value),
		.channel_scale       (channel_scale),
		.channel_bias        (channel_bias),
		.channel_right_shift (channel_right_shift),
		.mid_count           (mid_count),
		.mid_wr              (mid_wr),
		.mid_item            (mid_witem)
	);

	rqnt_fifo #(
		.WIDTH($bits(mid_item_t)),
		.DEPTH(MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (mid_wr),
		.wdata  (mid_witem),
		.rd     (mid_rd),
		.rdata  (mid_rdata),
		.empty  (mid_empty),
		.count  (mid_count)
	);

	rqnt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mid_empty (mid_empty),
		.mid_item  (mid_item_t'(mid_rdata)),
		.mid_rd    (mid_rd),
		.out_count (out_count),
		.out_wr    (out_wr),
		.out_item  (out_witem)
	);

	rqnt_fifo #(
		.WIDTH($bits(out_item_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (out_wr),
		.wdata  (out_witem),
		.rd     (pop),
		.rdata  (out_rdata),
		.empty  (empty),
		.count  (out_count)
	);

	assign out_ritem      = out_item_t'(out_rdata);
	assign result_value   = out_ritem.value;
	assign result_channel = out_ritem.channel;

endmodule

`default_nettype wire
